[design/utf8tc_pkg.sv]
// utf8tc_pkg: shared types and constants of the utf-8 transcoder
// used by the decode, encode and top level files; depends on nothing

package utf8tc_pkg;

	localparam int CpW = 21;

	localparam logic FMT_UTF32 = 1'b0;
	localparam logic FMT_UTF16 = 1'b1;

	localparam logic [2:0] COUNT_UNIT = 3'd2;
	localparam logic [2:0] COUNT_WORD = 3'd4;

	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [CpW-1:0] PLANE1_BASE = 21'h10000;

	// decoded code point handed from decode to encode
	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           last;
	} dec_t;

	// encoded result item
	typedef struct packed {
		logic [31:0] unit_bytes;
		logic [2:0]  byte_count;
		logic        string_end;
	} res_t;

endpackage

[design/utf8tc_decode.sv]
// utf8tc_decode: lenient utf-8 sequence decoder with accumulator state
// depends on utf8tc_pkg

module utf8tc_decode import utf8tc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] byte_in,
	input  logic       string_last,
	output logic       done,
	output dec_t       dec
);

	logic [CpW-1:0] acc_q;
	logic [1:0]     left_q;
	logic [CpW-1:0] acc_nx;
	logic [1:0]     left_nx;

	always_comb begin
		acc_nx  = acc_q;
		left_nx = left_q;
		if (left_q == 2'd0) begin
			unique if (byte_in[7] == 1'b0) begin
				acc_nx  = {13'd0, byte_in};
				left_nx = 2'd0;
			end else if (byte_in[7:5] == 3'b110) begin
				acc_nx  = {16'd0, byte_in[4:0]};
				left_nx = 2'd1;
			end else if (byte_in[7:4] == 4'b1110) begin
				acc_nx  = {17'd0, byte_in[3:0]};
				left_nx = 2'd2;
			end else if (byte_in[7:3] == 5'b11110) begin
				acc_nx  = {18'd0, byte_in[2:0]};
				left_nx = 2'd3;
			end else begin
				// stray continuation or invalid lead passes through as itself
				acc_nx  = {13'd0, byte_in};
				left_nx = 2'd0;
			end
		end else begin
			acc_nx  = {acc_q[CpW-7:0], byte_in[5:0]};
			left_nx = left_q - 2'd1;
		end
	end

	assign done     = (left_nx == 2'd0) || string_last;
	assign dec.cp   = acc_nx;
	assign dec.last = string_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			left_q <= 2'd0;
		end else if (accept) begin
			if (done) begin
				acc_q  <= '0;
				left_q <= 2'd0;
			end else begin
				acc_q  <= acc_nx;
				left_q <= left_nx;
			end
		end
	end

endmodule

[design/utf8tc_encode.sv]
// utf8tc_encode: packs a code point as utf-32le or utf-16le
// depends on utf8tc_pkg

module utf8tc_encode import utf8tc_pkg::*; (
	input  dec_t dec,
	input  logic output_format,
	output res_t res
);

	logic [CpW-1:0] v;
	logic [15:0]    hi;
	logic [15:0]    lo;
	logic           above_bmp;

	assign above_bmp = (dec.cp[CpW-1:16] != '0);
	assign v         = dec.cp - PLANE1_BASE;
	assign hi        = HI_SURR_BASE + {5'd0, v[CpW-1:10]};
	assign lo        = LO_SURR_BASE | {6'd0, v[9:0]};

	always_comb begin
		res.string_end = dec.last;
		if (output_format == FMT_UTF32) begin
			res.unit_bytes = {11'd0, dec.cp};
			res.byte_count = COUNT_WORD;
		end else if (above_bmp) begin
			res.unit_bytes = {lo, hi};
			res.byte_count = COUNT_WORD;
		end else begin
			res.unit_bytes = {16'd0, dec.cp[15:0]};
			res.byte_count = COUNT_UNIT;
		end
	end

endmodule

[design/utf8_to_utf32_utf16_transcoder.sv]
// utf8_to_utf32_utf16_transcoder: one utf-8 byte per cycle in, utf-32le/utf-16le out
// path: a completing byte's code point is registered in dec_s1, encoded, and
// registered in res_s2, whose valid drives m_tvalid
// throughput: one byte per cycle while m_tready holds, set by both stage registers
// reset: arst_n clears the accumulator, the stage valids and output_format (utf-32)
// depends on utf8tc_pkg, utf8tc_decode, utf8tc_encode

module utf8_to_utf32_utf16_transcoder import utf8tc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,   // output_format
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // byte_in
	input  logic        s_tlast,       // string_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,       // unit_bytes[31:0], byte_count[34:32], zero pad
	output logic        m_tlast        // string_end
);

	logic output_format_q;
	logic accept;
	logic done;
	dec_t dec;
	dec_t dec_s1;
	logic valid_s1;
	logic ready_s1;
	logic ready_s2;
	res_t res;
	res_t res_s2;
	logic valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_format_q <= FMT_UTF32;
		end else if (cfg_wr_en) begin
			output_format_q <= cfg_wr_data;
		end
	end

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign accept   = s_tvalid && ready_s1;

	utf8tc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.byte_in     (s_tdata),
		.string_last (s_tlast),
		.done        (done),
		.dec         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept && done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done) begin
			dec_s1 <= dec;
		end
	end

	utf8tc_encode u_encode (
		.dec           (dec_s1),
		.output_format (output_format_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.byte_count, res_s2.unit_bytes};
	assign m_tlast  = res_s2.string_end;

endmodule

[design/utf8tc_checker.sv]
// utf8tc_checker: port-level checks on the transcoder result stream
// depends on utf8_to_utf32_utf16_transcoder, attached by bind

module utf8tc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// a held result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] == 3'd2 || m_tdata[34:32] == 3'd4))
		else $error("byte count not 2 or 4");

	// a single utf-16 unit leaves the upper half empty
	a_unit_upper: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:32] == 3'd2 |-> m_tdata[31:16] == 16'd0)
		else $error("utf-16 unit with upper bits set");

	// the last item of a string always produces a result, so m_tvalid is up after it
	a_last_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> ##1 m_tvalid)
		else $error("no result two cycles after the last item of a string");

endmodule

bind utf8_to_utf32_utf16_transcoder utf8tc_checker u_chk (.*);

[bench/tb_top.sv]
// tb_top: self-checking bench for the utf-8 to utf-32/utf-16 transcoder
// random and directed byte strings are checked against a behavioral decoder
// depends on utf8tc_pkg and utf8_to_utf32_utf16_transcoder
`timescale 1ns / 100ps

module tb_top;
	import utf8tc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_LEN     = 200;
	localparam int SETTLE       = 8;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	utf8_to_utf32_utf16_transcoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	byte_item_t pending_bytes[$];
	res_t       expected_units[$];

	// decoder state mirrored from the block
	logic [CpW-1:0] pred_cp = '0;
	logic [1:0]     pred_left = '0;
	logic           pred_fmt = FMT_UTF32;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	logic hold_go = 1'b0;
	int hold_cnt = 0;

	int n_bytes = 0;
	int n_units = 0;
	int n_pairs = 0;
	int n_errors = 0;
	int n_mismatch = 0;
	int cycles = 0;

	function automatic bit transcode_byte(input logic [7:0] b, input logic last,
			output res_t r);
		logic [CpW-1:0] v;
		logic [15:0] hi;
		logic [15:0] lo;
		if (pred_left == 2'd0) begin
			casez (b)
				8'b0???????: begin pred_cp = {13'd0, b}; pred_left = 2'd0; end
				8'b110?????: begin pred_cp = {16'd0, b[4:0]}; pred_left = 2'd1; end
				8'b1110????: begin pred_cp = {17'd0, b[3:0]}; pred_left = 2'd2; end
				8'b11110???: begin pred_cp = {18'd0, b[2:0]}; pred_left = 2'd3; end
				// stray continuation or invalid lead stands for itself
				default: begin pred_cp = {13'd0, b}; pred_left = 2'd0; end
			endcase
		end else begin
			// any byte counts as a continuation, top bits ignored
			pred_cp = {pred_cp[CpW-7:0], b[5:0]};
			pred_left = pred_left - 2'd1;
		end
		r = '0;
		if (pred_left != 2'd0 && !last)
			return 1'b0;
		r.string_end = last;
		if (pred_fmt == FMT_UTF32) begin
			r.unit_bytes = {11'd0, pred_cp};
			r.byte_count = COUNT_WORD;
		end else if (pred_cp >= PLANE1_BASE) begin
			v = pred_cp - PLANE1_BASE;
			hi = HI_SURR_BASE + {5'd0, v[20:10]};
			lo = LO_SURR_BASE + {6'd0, v[9:0]};
			r.unit_bytes = {lo, hi};
			r.byte_count = COUNT_WORD;
		end else begin
			r.unit_bytes = {16'd0, pred_cp[15:0]};
			r.byte_count = COUNT_UNIT;
		end
		pred_cp = '0;
		pred_left = 2'd0;
		return 1'b1;
	endfunction

	// driver: valid held until taken, next item picked after acceptance
	always @(posedge clk) begin
		byte_item_t it;
		res_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				n_bytes++;
				if (transcode_byte(s_tdata, s_tlast, r))
					expected_units.insert(expected_units.size(), r);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					it = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.data;
					s_tlast <= it.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off to back the pipeline up into the input
	always @(posedge clk) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_go)
			hold_cnt <= HOLD_LEN;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	// monitor: compare each result with the oldest expected one
	always @(posedge clk) begin
		res_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_units++;
				if (expected_units.size() == 0) begin
					n_errors++;
					if (n_mismatch < 10)
						$display("unexpected result: bytes %h count %0d end %0b",
							m_tdata[31:0], m_tdata[34:32], m_tlast);
					n_mismatch++;
				end else begin
					e = expected_units.pop_front();
					if (e.byte_count == COUNT_WORD && m_tdata[34:32] == COUNT_WORD
							&& pred_fmt == FMT_UTF16)
						n_pairs++;
					if (m_tdata[31:0] !== e.unit_bytes || m_tdata[34:32] !== e.byte_count
							|| m_tlast !== e.string_end) begin
						n_errors++;
						if (n_mismatch < 10)
							$display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
								e.unit_bytes, e.byte_count, e.string_end,
								m_tdata[31:0], m_tdata[34:32], m_tlast);
						n_mismatch++;
					end
				end
			end
			m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic last);
		byte_item_t it;
		it.data = d;
		it.last = last;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	task automatic add_directed();
		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hF8, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b0);
		push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
		push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0);
		push_byte(8'h98, 1'b0); push_byte(8'h80, 1'b0);
		// largest value the accumulator can hold
		push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
		// encoded surrogate passes unchanged
		push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
		// continuation without the 10 prefix
		push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
		// string cut mid-sequence, then a lone lead as the last byte
		push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
		push_byte(8'hF0, 1'b1);
	endtask

	task automatic add_string(inout int pushed);
		logic [7:0] str[$];
		int nchars;
		int kind;
		int len;
		nchars = $urandom_range(1, 10);
		for (int c = 0; c < nchars; c++) begin
			kind = $urandom_range(99);
			if (kind < 70 || kind >= 90) begin
				len = $urandom_range(1, 4);
				case (len)
					1: str.insert(str.size(), {1'b0, 7'($urandom)});
					2: str.insert(str.size(), {3'b110, 5'($urandom)});
					3: str.insert(str.size(), {4'b1110, 4'($urandom)});
					default: str.insert(str.size(), {5'b11110, 3'($urandom)});
				endcase
				for (int k = 1; k < len; k++) begin
					// truncated string: stop after some continuation bytes
					if (kind >= 90 && k == $urandom_range(1, len - 1))
						break;
					str.insert(str.size(), {2'b10, 6'($urandom)});
				end
				if (kind >= 90)
					break;
			end else if (kind < 80) begin
				str.insert(str.size(), 8'($urandom));
			end else begin
				// sequence with a malformed continuation
				str.insert(str.size(), {3'b110, 5'($urandom)});
				str.insert(str.size(), 8'($urandom));
			end
		end
		for (int i = 0; i < str.size(); i++)
			push_byte(str[i], i == str.size() - 1);
		pushed += str.size();
	endtask

	task automatic add_random(input int n);
		int pushed;
		pushed = 0;
		while (pushed < n)
			add_string(pushed);
	endtask

	task automatic write_format(input logic f);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pred_fmt = f;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || expected_units.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input logic f, input int src_pct, input int sink_pct,
			input bit directed, input int n_rand);
		write_format(f);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		if (directed)
			add_directed();
		add_random(n_rand);
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset value of the format register first
		add_directed();
		drain();

		run_phase(FMT_UTF16, 0, 0, 1'b1, 200);
		run_phase(FMT_UTF32, 84, 0, 1'b0, 220);
		run_phase(FMT_UTF16, 0, 84, 1'b0, 220);
		run_phase(FMT_UTF32, 20, 20, 1'b0, 220);
		run_phase(FMT_UTF16, 20, 20, 1'b0, 150);

		// receiver holds off while the sender keeps offering
		write_format(FMT_UTF32);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		add_random(220);
		drain();

		$display("checked %0d code points (%0d surrogate pairs) from %0d bytes",
			n_units, n_pairs, n_bytes);
		$display("both output formats, all lead kinds, truncated and malformed strings");
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
